/* sv/bfm_pkg.sv */
// Shared types and constants of the 3x3 box mean filter.
package bfm_pkg;

    // Command field of an input item
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    localparam t_cfg_index REG_WIDTH  = t_cfg_index'(0);
    localparam t_cfg_index REG_HEIGHT = t_cfg_index'(1);
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;

    // Frame geometry
    localparam int MAX_HEIGHT   = 4096;
    localparam int ROW_BITS     = 12;  // row inside the frame
    localparam int IN_ROW_BITS  = 13;  // input row, runs past the frame while draining
    localparam int RST_WIDTH    = 1024;
    localparam int RST_HEIGHT   = 1024;

    // Pixel ports
    localparam int PIX_PORT_BITS = 16;

    // Division by nine: q = (s * DIV9_MUL) >> DIV9_SHIFT, exact for s < 2**SUM_BITS_MAX
    localparam int SUM_BITS_MAX = 20;
    localparam int DIV9_BITS    = 21;
    localparam int DIV9_SHIFT   = 24;
    localparam logic [DIV9_BITS-1:0] DIV9_MUL = 21'd1864136;
    localparam int PROD_BITS    = SUM_BITS_MAX + DIV9_BITS;

    // Queue size between front and back
    localparam int QUEUE_DEPTH = 4;

    // Classification of one item, carried from the front to the back
    typedef struct packed {
        logic emit;    // item releases one result
        logic border;  // result passes the centre through
        logic last;    // result closes the frame
    } t_work_ctl;

endpackage

/* sv/bfm_front.sv */
// Front end: configuration registers, raster counters and item classification.
module bfm_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  bfm_pkg::t_cfg_index                 i_cfg_index,
    input  logic [bfm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_accept,
    input  logic                                i_command,
    input  logic [bfm_pkg::PIX_PORT_BITS-1:0]   i_pixel_in,
    output logic                                o_push,
    output logic [PIXEL_BITS-1:0]               o_pix,
    output logic [COL_BITS-1:0]                 o_col,
    output bfm_pkg::t_work_ctl                  o_ctl
);
    import bfm_pkg::*;

    localparam int W_RST = (MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH;

    logic [COL_BITS-1:0]    r_w_last, n_w_last;
    logic [ROW_BITS-1:0]    r_h_last, n_h_last;
    logic [IN_ROW_BITS-1:0] r_in_row, n_in_row;
    logic [COL_BITS-1:0]    r_in_col, n_in_col;
    logic [ROW_BITS-1:0]    r_out_row, n_out_row;
    logic [COL_BITS-1:0]    r_out_col, n_out_col;

    logic                   w_tail;
    logic                   w_skip;
    logic                   w_emit;
    logic                   w_border;
    logic                   w_last;
    logic [12:0]            w_wval;
    logic [12:0]            w_hval;

    assign w_tail   = r_in_row > IN_ROW_BITS'(r_h_last);
    assign w_skip   = !w_tail && (i_command == CMD_DRAIN);
    assign w_emit   = (r_in_row >= IN_ROW_BITS'(2))
                   || ((r_in_row == IN_ROW_BITS'(1)) && (r_in_col != '0));
    assign w_border = (r_out_row == '0) || (r_out_row == r_h_last)
                   || (r_out_col == '0) || (r_out_col == r_w_last);
    assign w_last   = (r_out_row == r_h_last) && (r_out_col == r_w_last);

    assign o_push = i_accept && !w_skip;
    assign o_pix  = w_tail ? '0 : i_pixel_in[PIXEL_BITS-1:0];
    assign o_col  = r_in_col;
    assign o_ctl  = '{emit: w_emit, border: w_border, last: w_last};

    assign w_wval = {2'b00, i_cfg_data[WIDTH_REG_BITS-1:0]};
    assign w_hval = i_cfg_data[HEIGHT_REG_BITS-1:0];

    always_comb begin
        n_w_last  = r_w_last;
        n_h_last  = r_h_last;
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH: begin
                    if (w_wval == '0) begin
                        n_w_last = '0;
                    end else if (w_wval > 13'(MAX_WIDTH)) begin
                        n_w_last = COL_BITS'(MAX_WIDTH - 1);
                    end else begin
                        n_w_last = COL_BITS'(w_wval - 13'd1);
                    end
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end
                REG_HEIGHT: begin
                    if (w_hval == '0) begin
                        n_h_last = '0;
                    end else if (w_hval > 13'(MAX_HEIGHT)) begin
                        n_h_last = ROW_BITS'(MAX_HEIGHT - 1);
                    end else begin
                        n_h_last = ROW_BITS'(w_hval - 13'd1);
                    end
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end
                default: begin
                end
            endcase
        end else if (o_push) begin
            if (r_in_col == r_w_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_BITS'(1);
            end else begin
                n_in_col = r_in_col + COL_BITS'(1);
            end
            if (w_emit) begin
                if (r_out_col == r_w_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_BITS'(1);
                end else begin
                    n_out_col = r_out_col + COL_BITS'(1);
                end
                // closing result starts the next frame
                if (w_last) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last  <= COL_BITS'(W_RST - 1);
            r_h_last  <= ROW_BITS'(RST_HEIGHT - 1);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_w_last  <= n_w_last;
            r_h_last  <= n_h_last;
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    a_in_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= r_w_last)
        else $error("input column beyond row end");

    a_out_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_col <= r_w_last) && (r_out_row <= r_h_last))
        else $error("output position outside the frame");

endmodule

/* sv/bfm_fifo.sv */
// Small register queue between the front end and the back end.
module bfm_fifo #(
    parameter int DATA_BITS = 32,
    parameter int DEPTH     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_rd_data,
    output logic                 o_full,
    output logic                 o_empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]  r_count, n_count;

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_BITS'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");

endmodule

/* sv/bfm_back.sv */
// Back end: line buffers, 3x3 window, divide by nine and output register.
module bfm_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_pop,
    input  logic [PIXEL_BITS-1:0]             i_pix,
    input  logic [COL_BITS-1:0]               i_col,
    input  bfm_pkg::t_work_ctl                i_ctl,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bfm_pkg::PIX_PORT_BITS-1:0] o_pixel_out,
    output logic                              o_frame_end
);
    import bfm_pkg::*;

    localparam int CS_BITS  = PIXEL_BITS + 2;
    localparam int SUM_BITS = PIXEL_BITS + 4;

    logic                  w_adv;

    // line buffers
    logic [PIXEL_BITS-1:0] r_line1 [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_line2 [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd1;
    logic [PIXEL_BITS-1:0] r_rd2;

    // stage 1: item with its column read back
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [COL_BITS-1:0]   r_s1_col;
    t_work_ctl             r_s1_ctl;
    logic                  r_s1_fwd;
    logic [PIXEL_BITS-1:0] r_s1_fwd_pix;
    logic [PIXEL_BITS-1:0] w_above1;
    logic [PIXEL_BITS-1:0] w_above2;
    logic [CS_BITS-1:0]    w_colsum;

    // window, kept as column sums plus the centre column's middle tap
    logic [CS_BITS-1:0]    r_cs0, r_cs1, r_cs2;
    logic [PIXEL_BITS-1:0] r_mid0, r_mid1;

    // stage 2..4
    logic                  r_s2_valid;
    logic                  r_s2_border;
    logic                  r_s2_last;
    logic                  r_s3_valid;
    logic                  r_s3_border;
    logic                  r_s3_last;
    logic [SUM_BITS-1:0]   r_s3_sum;
    logic [PIXEL_BITS-1:0] r_s3_center;
    logic                  r_s4_valid;
    logic                  r_s4_border;
    logic                  r_s4_last;
    logic [PROD_BITS-1:0]  r_s4_prod;
    logic [PIXEL_BITS-1:0] r_s4_center;
    logic [SUM_BITS_MAX-1:0] w_sum_ext;
    logic [PIXEL_BITS-1:0] w_quot;

    logic                  r_out_valid;
    logic [PIX_PORT_BITS-1:0] r_pixel_out;
    logic                  r_frame_end;

    // whole back pipeline moves together; only a stalled full output holds it
    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_pop = w_adv && i_valid;

    assign w_above1 = r_rd1;
    assign w_above2 = r_s1_fwd ? r_s1_fwd_pix : r_rd2;
    assign w_colsum = CS_BITS'(w_above2) + CS_BITS'(w_above1) + CS_BITS'(r_s1_pix);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd1          <= r_line1[i_col];
            r_line1[i_col] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd2 <= r_line2[i_col];
        end
        if (w_adv && r_s1_valid) begin
            r_line2[r_s1_col] <= w_above1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid && r_s1_ctl.emit;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_pix     <= i_pix;
            r_s1_col     <= i_col;
            r_s1_ctl     <= i_ctl;
            // same column written back this edge: take the value in flight
            r_s1_fwd     <= r_s1_valid && (r_s1_col == i_col);
            r_s1_fwd_pix <= w_above1;
        end
        if (w_adv && r_s1_valid) begin
            r_cs0  <= r_cs1;
            r_cs1  <= r_cs2;
            r_cs2  <= w_colsum;
            r_mid0 <= r_mid1;
            r_mid1 <= w_above1;
        end
        if (w_adv) begin
            r_s2_border <= r_s1_ctl.border;
            r_s2_last   <= r_s1_ctl.last;
            r_s3_border <= r_s2_border;
            r_s3_last   <= r_s2_last;
            r_s3_sum    <= SUM_BITS'(r_cs0) + SUM_BITS'(r_cs1) + SUM_BITS'(r_cs2);
            r_s3_center <= r_mid0;
            r_s4_border <= r_s3_border;
            r_s4_last   <= r_s3_last;
            r_s4_prod   <= PROD_BITS'(w_sum_ext) * PROD_BITS'(DIV9_MUL);
            r_s4_center <= r_s3_center;
            r_pixel_out <= PIX_PORT_BITS'(r_s4_border ? r_s4_center : w_quot);
            r_frame_end <= r_s4_last;
        end
    end

    assign w_sum_ext = SUM_BITS_MAX'(r_s3_sum);
    assign w_quot    = r_s4_prod[DIV9_SHIFT +: PIXEL_BITS];

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_frame_end = r_frame_end;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_s1_valid) && $stable(r_s2_valid)
                   && $stable(r_s3_valid) && $stable(r_s4_valid))
        else $error("back pipeline moved while output stalled");

endmodule

/* sv/box_filter_3x3_mean.sv */
// Top level of the 3x3 box mean filter.
// Takes a grayscale frame one pixel item a clock in raster order while o_in_stall is low and
// returns, one item a clock while i_out_stall is low, the 3x3 mean (sum of nine, divided by
// nine, truncated) of each interior pixel; border pixels and frames narrower or shorter than
// three pass through. Results trail the input by one row and one pixel, so after the last
// pixel send width + 1 drain items. A front end classifies items and keeps the raster
// counters; a four-entry queue feeds the back end (line buffers with one read and one write
// a cycle, window, divide by nine as a registered multiply), which has five registered
// stages. Input stalls only while the queue is full, i.e. while the output side stalls. Write
// configuration only while idle; a write restarts the frame.
module box_filter_3x3_mean #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  bfm_pkg::t_cfg_index               i_cfg_index,
    input  logic [bfm_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [bfm_pkg::PIX_PORT_BITS-1:0] i_pixel_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bfm_pkg::PIX_PORT_BITS-1:0] o_pixel_out,
    output logic                              o_frame_end
);
    import bfm_pkg::*;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ENTRY_BITS = $bits(t_work_ctl) + COL_BITS + PIXEL_BITS;

    logic                  w_accept;
    logic                  w_push;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [COL_BITS-1:0]   w_col;
    t_work_ctl             w_ctl;
    logic [ENTRY_BITS-1:0] w_wr_data;
    logic [ENTRY_BITS-1:0] w_rd_data;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_pop;
    logic [PIXEL_BITS-1:0] w_q_pix;
    logic [COL_BITS-1:0]   w_q_col;
    t_work_ctl             w_q_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;

    bfm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_command   (i_command),
        .i_pixel_in  (i_pixel_in),
        .o_push      (w_push),
        .o_pix       (w_pix),
        .o_col       (w_col),
        .o_ctl       (w_ctl)
    );

    assign w_wr_data = {w_ctl, w_col, w_pix};
    assign {w_q_ctl, w_q_col, w_q_pix} = w_rd_data;

    bfm_fifo #(
        .DATA_BITS (ENTRY_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_wr_data),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_data),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    bfm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!w_empty),
        .o_pop       (w_pop),
        .i_pix       (w_q_pix),
        .i_col       (w_q_col),
        .i_ctl       (w_q_ctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end)
    );

endmodule
